// File: hdl/dstb_pkg.sv
package dstb_pkg;

    // Field widths.
    localparam int ELAPSED_W = 16;
    localparam int PERIOD_W  = 20;
    localparam int ACCUM_W   = 21;
    localparam int TRACK_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    // Register values after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(10000);
    localparam logic [TRACK_W-1:0]  MAX_TRACK_RESET = TRACK_W'(74);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_A    = 2'd0,
        CFG_PERIOD_B    = 2'd1,
        CFG_MAX_TRACK_A = 2'd2,
        CFG_MAX_TRACK_B = 2'd3
    } t_cfg_idx;

    // State of one stepper channel.
    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        logic [TRACK_W-1:0] track;
        logic               reverse;
    } t_chan_state;

    // Next state of one channel and whether it stepped.
    typedef struct packed {
        t_chan_state state;
        logic        step;
    } t_chan_next;

    // Result word, last field (step_a) in the lowest bits.
    typedef struct packed {
        logic [TRACK_W-1:0] track_b;
        logic               dir_b;
        logic               step_b;
        logic [TRACK_W-1:0] track_a;
        logic               dir_a;
        logic               step_a;
    } t_result;

    // One item for one channel: unless the period is zero, accumulate, compare, then on a step bounce the head.
    function automatic t_chan_next chan_next(
        input t_chan_state         cur,
        input logic [PERIOD_W-1:0] period,
        input logic [TRACK_W-1:0]  max_track,
        input logic [ELAPSED_W-1:0] elapsed
    );
        t_chan_next         res;
        logic [ACCUM_W-1:0] sum;
        logic               rev;
        res  = '{state: cur, step: 1'b0};
        sum  = cur.accum + ACCUM_W'(elapsed);
        rev  = cur.reverse;
        if (period != '0) begin
            if (sum < ACCUM_W'(period)) begin
                res.state.accum = sum;
            end else begin
                res.step        = 1'b1;
                res.state.accum = '0;
                if (cur.track >= max_track) begin
                    rev = 1'b1;
                end else if (cur.track == '0) begin
                    rev = 1'b0;
                end
                res.state.reverse = rev;
                res.state.track   = rev ? cur.track - TRACK_W'(1)
                                        : cur.track + TRACK_W'(1);
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/dual_stepper_tone_bouncer_top.sv
// An accepted word is registered in the output stage, or in the skid stage on a stall.
// Throughput: one word per cycle while the skid stage is empty; the channel update is one
// accumulate, one compare and one track increment or decrement, done in the cycle of
// acceptance. Reset (synchronous, active low): periods 10000 us, maximum tracks 74,
// accumulators, tracks and directions zero, output and skid stages empty.
module dual_stepper_tone_bouncer_top
    import dstb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [PERIOD_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,  // [15:0] elapsed_us
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata   // [0] step_a, [1] dir_a, [9:2] track_a,
                                                // [10] step_b, [11] dir_b,
                                                // [19:12] track_b, [23:20] zero
);

    logic [PERIOD_W-1:0] r_period_a;
    logic [PERIOD_W-1:0] r_period_b;
    logic [TRACK_W-1:0]  r_max_a;
    logic [TRACK_W-1:0]  r_max_b;
    t_chan_state         r_chan_a;
    t_chan_state         r_chan_b;
    t_result             r_out_data;
    logic                r_out_valid;
    t_result             r_skid_data;
    logic                r_skid_valid;

    t_chan_next          w_next_a;
    t_chan_next          w_next_b;
    t_result             w_res;
    logic                w_accept;
    logic                w_out_fire;
    logic [ELAPSED_W-1:0] w_elapsed;

    // Handshakes: the skid stage holds a word when the output stalls.
    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = r_out_valid && m_axis_tready;
    assign w_elapsed     = s_axis_tdata[ELAPSED_W-1:0];

    // Channel updates for the incoming word.
    always_comb begin
        w_next_a      = chan_next(r_chan_a, r_period_a, r_max_a, w_elapsed);
        w_next_b      = chan_next(r_chan_b, r_period_b, r_max_b, w_elapsed);
        w_res.step_a  = w_next_a.step;
        w_res.dir_a   = w_next_a.state.reverse;
        w_res.track_a = w_next_a.state.track;
        w_res.step_b  = w_next_b.step;
        w_res.dir_b   = w_next_b.state.reverse;
        w_res.track_b = w_next_b.state.track;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_a <= PERIOD_RESET;
            r_period_b <= PERIOD_RESET;
            r_max_a    <= MAX_TRACK_RESET;
            r_max_b    <= MAX_TRACK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PERIOD_A:    r_period_a <= i_cfg_wdata;
                CFG_PERIOD_B:    r_period_b <= i_cfg_wdata;
                CFG_MAX_TRACK_A: r_max_a    <= i_cfg_wdata[TRACK_W-1:0];
                CFG_MAX_TRACK_B: r_max_b    <= i_cfg_wdata[TRACK_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_a <= '0;
            r_chan_b <= '0;
        end else if (w_accept) begin
            r_chan_a <= w_next_a.state;
            r_chan_b <= w_next_b.state;
        end
    end

    // Output stage and skid stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (!r_out_valid || w_out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_fire) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    // Output and skid payloads.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_data <= w_res;
            end else begin
                r_skid_data <= w_res;
            end
        end else if (w_out_fire && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - $bits(t_result)){1'b0}}, r_out_data};

    // A word waits in the skid stage only behind a stalled output word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a word while the output stage is empty");

    // A disabled channel keeps its accumulator.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_period_a == '0) |=> $stable(r_chan_a.accum))
        else $error("channel A accumulator moved while disabled");

    // A step clears the accumulator.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_next_b.step) |=> (r_chan_b.accum == '0))
        else $error("channel B accumulator not cleared after a step");

endmodule

// File: bench/dual_stepper_tone_bouncer_top_tb.sv
module dual_stepper_tone_bouncer_top_tb
    import dstb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_addr;
    logic [PERIOD_W-1:0]  i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;   // [15:0] elapsed_us
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;   // [0] step_a, [1] dir_a, [9:2] track_a,
                                          // [10] step_b, [11] dir_b, [19:12] track_b

    dual_stepper_tone_bouncer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the stepper channels and their registers.
    logic [PERIOD_W-1:0] period_r  [2];
    logic [TRACK_W-1:0]  max_trk_r [2];
    logic [ACCUM_W-1:0]  accum_r   [2];
    logic [TRACK_W-1:0]  track_r   [2];
    logic                reverse_r [2];

    // Head words predicted for accepted input words, oldest first.
    t_result pending_heads [$];

    int mismatch_count = 0;
    int words_checked  = 0;
    int steps_a_seen   = 0;
    int steps_b_seen   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    // Clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Advance one channel by the elapsed time; returns one when it steps.
    function automatic logic advance_channel(input int ch, input logic [ELAPSED_W-1:0] us);
        logic [ACCUM_W-1:0] sum;
        if (period_r[ch] == '0) begin
            return 1'b0;
        end
        sum = accum_r[ch] + ACCUM_W'(us);
        if (sum < ACCUM_W'(period_r[ch])) begin
            accum_r[ch] = sum;
            return 1'b0;
        end
        accum_r[ch] = '0;
        // Bounce off the top first, then off track zero.
        if (track_r[ch] >= max_trk_r[ch]) begin
            reverse_r[ch] = 1'b1;
        end else if (track_r[ch] == '0) begin
            reverse_r[ch] = 1'b0;
        end
        track_r[ch] = reverse_r[ch] ? track_r[ch] - TRACK_W'(1) : track_r[ch] + TRACK_W'(1);
        return 1'b1;
    endfunction

    function automatic t_result predict_heads(input logic [ELAPSED_W-1:0] us);
        t_result r;
        r.step_a  = advance_channel(0, us);
        r.dir_a   = reverse_r[0];
        r.track_a = track_r[0];
        r.step_b  = advance_channel(1, us);
        r.dir_b   = reverse_r[1];
        r.track_b = track_r[1];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: word %0d field %s: got %0h, expected %0h",
                 $realtime, words_checked, what, got, want);
    endtask

    // Predict a head word for every accepted input word.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_heads.push_back(predict_heads(s_axis_tdata[ELAPSED_W-1:0]));
        end
    end

    // Compare every accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_heads.size() == 0) begin
                report_mismatch("unexpected word", int'(m_axis_tdata), 0);
            end else begin
                want = pending_heads.pop_front();
                if (got.step_a !== want.step_a)   report_mismatch("step_a", got.step_a, want.step_a);
                if (got.dir_a !== want.dir_a)     report_mismatch("dir_a", got.dir_a, want.dir_a);
                if (got.track_a !== want.track_a) report_mismatch("track_a", got.track_a, want.track_a);
                if (got.step_b !== want.step_b)   report_mismatch("step_b", got.step_b, want.step_b);
                if (got.dir_b !== want.dir_b)     report_mismatch("dir_b", got.dir_b, want.dir_b);
                if (got.track_b !== want.track_b) report_mismatch("track_b", got.track_b, want.track_b);
                if (m_axis_tdata[M_DATA_W-1:$bits(t_result)] !== '0) begin
                    report_mismatch("padding", int'(m_axis_tdata[M_DATA_W-1:$bits(t_result)]), 0);
                end
            end
            words_checked++;
            if (got.step_a === 1'b1) steps_a_seen++;
            if (got.step_b === 1'b1) steps_b_seen++;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word and wait until it is taken; entered and left at a falling edge.
    task automatic send_word(input logic [ELAPSED_W-1:0] us);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= us;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_heads.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Register write; only called while the block is drained.
    task automatic write_reg(input t_cfg_idx idx, input logic [PERIOD_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_PERIOD_A:    period_r[0]  = val;
            CFG_PERIOD_B:    period_r[1]  = val;
            CFG_MAX_TRACK_A: max_trk_r[0] = val[TRACK_W-1:0];
            CFG_MAX_TRACK_B: max_trk_r[1] = val[TRACK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [PERIOD_W-1:0] random_period();
        case ($urandom_range(7))
            0:       return '0;
            1:       return PERIOD_W'(1);
            2:       return '1;
            3:       return PERIOD_W'($urandom_range(1, 300));
            4, 5:    return PERIOD_W'($urandom_range(1, 30000));
            6:       return PERIOD_W'($urandom_range(1, 20'hFFFFF));
            default: return PERIOD_RESET;
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] random_max_track();
        case ($urandom_range(3))
            0:       return '0;
            1:       return PERIOD_W'(255);
            2:       return PERIOD_W'($urandom_range(1, 8));
            default: return PERIOD_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return ELAPSED_W'($urandom_range(0, 15));
            3, 4:    return ELAPSED_W'($urandom_range(0, 65535));
            default: return ELAPSED_W'($urandom_range(0, 4000));
        endcase
    endfunction

    // Default registers: no step until 10000 us, then extremes of the elapsed field.
    task automatic test_reset_values();
        send_word('0);
        send_word(ELAPSED_W'(9999));
        send_word(ELAPSED_W'(1));
        send_word('1);
        send_word('1);
        wait_drained();
    endtask

    // A disabled channel holds its accumulator; a lowered period steps at once.
    task automatic test_disable_and_low_period();
        write_reg(CFG_PERIOD_B, '0);
        send_word(ELAPSED_W'(30000));
        send_word(ELAPSED_W'(5000));
        wait_drained();
        write_reg(CFG_PERIOD_A, PERIOD_W'(100));
        send_word('0);
        wait_drained();
        write_reg(CFG_PERIOD_B, PERIOD_W'(3000));
        send_word('0);
        send_word(ELAPSED_W'(1000));
        wait_drained();
    endtask

    // Track above a lowered maximum, and a maximum of zero that wraps the track.
    task automatic test_track_limits();
        write_reg(CFG_PERIOD_A, PERIOD_W'(1));
        write_reg(CFG_PERIOD_B, PERIOD_W'(1));
        write_reg(CFG_MAX_TRACK_B, '0);
        repeat (6) send_word(ELAPSED_W'(1));
        wait_drained();
        write_reg(CFG_MAX_TRACK_A, PERIOD_W'(2));
        repeat (4) send_word(ELAPSED_W'(2));
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 60;
        repeat (30) send_word(random_elapsed());
        wait_drained();
    endtask

    // The sender pauses until every word is out, then picks up again.
    task automatic test_pause_until_drained();
        repeat (10) send_word(random_elapsed());
        wait_drained();
        repeat (10) send_word(random_elapsed());
        wait_drained();
    endtask

    // Random phases, each with fresh register settings and its own idling.
    task automatic test_random_traffic();
        int n_items;
        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 68;
            end else if (ph < 6) begin
                send_idle_pct = 68;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            n_items = 60;
            if (ph == 6) begin
                // Stepping on almost every word walks channel A to the top track.
                write_reg(CFG_PERIOD_A, PERIOD_W'(1));
                write_reg(CFG_MAX_TRACK_A, PERIOD_W'(255));
                n_items = 300;
            end else begin
                write_reg(CFG_PERIOD_A, random_period());
                write_reg(CFG_MAX_TRACK_A, random_max_track());
            end
            write_reg(CFG_PERIOD_B, random_period());
            write_reg(CFG_MAX_TRACK_B, random_max_track());
            repeat (n_items) send_word(random_elapsed());
        end
        wait_drained();
    endtask

    // Reset values of the shadow copy.
    task automatic reset_shadow();
        for (int ch = 0; ch < 2; ch++) begin
            period_r[ch]  = PERIOD_RESET;
            max_trk_r[ch] = MAX_TRACK_RESET;
            accum_r[ch]   = '0;
            track_r[ch]   = '0;
            reverse_r[ch] = 1'b0;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_PERIOD_A;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        reset_shadow();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_disable_and_low_period();
        test_track_limits();
        test_output_backpressure();
        send_idle_pct = 35;
        recv_idle_pct = 35;
        test_pause_until_drained();
        test_random_traffic();

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (pending_heads.size() != 0) begin
            report_mismatch("words never received", pending_heads.size(), 0);
        end
        $display("Checked %0d head words with %0d steps on channel A and %0d on channel B,",
                 words_checked, steps_a_seen, steps_b_seen);
        $display("over disabled, lowered and extreme periods and track limits with stalls.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(2_000_000);
        $display("Timeout waiting for the block to finish.");
        $display("Mismatches found");
        $finish;
    end

endmodule
